/* rtl/skt_pkg.sv */
// Package with shared types, codes and defaults for the sorted key table.
`timescale 1ns / 1ps

package skt_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int NAME_BYTES_DEF = 8;
  localparam int KEY_W          = 32;
  localparam int NAME_MAX_W     = 64;
  localparam int COUNT_W        = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                    command;
    logic signed [KEY_W-1:0] key;
    logic [NAME_MAX_W-1:0]   name_payload;
  } skt_in_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   entry_count;
  } skt_out_t;

  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [KEY_W-1:0] key;
    logic [NAME_MAX_W-1:0]   name;
  } skt_op_t;

  typedef struct packed {
    logic ge_ins;
    logic ge_del;
  } skt_flags_t;

endpackage

/* rtl/skt_cell.sv */
// One storage cell of the sorted table: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps

module skt_cell import skt_pkg::*; #(
  parameter int NAME_W = 8 * NAME_BYTES_DEF
) (
  input  logic                    clk,
  input  skt_op_t                 op,
  input  logic                    valid,
  input  logic                    match_any,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic [NAME_W-1:0]       left_name,
  input  skt_flags_t              left_flags,
  input  logic signed [KEY_W-1:0] right_key,
  input  logic [NAME_W-1:0]       right_name,
  output logic signed [KEY_W-1:0] key,
  output logic [NAME_W-1:0]       name,
  output skt_flags_t              flags,
  output logic                    hit
);

  logic                    cmp;
  logic signed [KEY_W-1:0] key_next;
  logic [NAME_W-1:0]       name_next;

  assign cmp          = (key >= op.key);
  assign flags.ge_ins = !valid || cmp;
  assign flags.ge_del = valid && cmp;
  assign hit          = flags.ge_del && !left_flags.ge_del && (key == op.key);

  always_comb begin
    key_next  = key;
    name_next = name;
    priority if (op.ins && left_flags.ge_ins) begin
      key_next  = left_key;
      name_next = left_name;
    end else if (op.ins && flags.ge_ins) begin
      key_next  = op.key;
      name_next = op.name[NAME_W-1:0];
    end else if (op.del && match_any && flags.ge_del) begin
      key_next  = right_key;
      name_next = right_name;
    end
  end

  always_ff @(posedge clk) begin
    key  <= key_next;
    name <= name_next;
  end

endmodule

/* rtl/skt_chain.sv */
// Row of storage cells with the delete match reduction.
`timescale 1ns / 1ps

module skt_chain import skt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int NAME_W   = 8 * NAME_BYTES_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  skt_op_t          op,
  input  logic [CNT_W-1:0] count,
  output logic             found
);

  logic signed [KEY_W-1:0] cell_key  [CAPACITY];
  logic [NAME_W-1:0]       cell_name [CAPACITY];
  skt_flags_t              cell_flags[CAPACITY];
  logic [CAPACITY-1:0]     hit;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] lk;
    logic [NAME_W-1:0]       ln;
    skt_flags_t              lf;
    logic signed [KEY_W-1:0] rk;
    logic [NAME_W-1:0]       rn;
    logic                    valid;

    if (i == 0) begin : g_first
      assign lk = '0;
      assign ln = '0;
      assign lf = '0;
    end else begin : g_inner
      assign lk = cell_key[i-1];
      assign ln = cell_name[i-1];
      assign lf = cell_flags[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rk = cell_key[i];
      assign rn = cell_name[i];
    end else begin : g_body
      assign rk = cell_key[i+1];
      assign rn = cell_name[i+1];
    end

    assign valid = (CNT_W'(i) < count);

    skt_cell #(
      .NAME_W(NAME_W)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .valid     (valid),
      .match_any (found),
      .left_key  (lk),
      .left_name (ln),
      .left_flags(lf),
      .right_key (rk),
      .right_name(rn),
      .key       (cell_key[i]),
      .name      (cell_name[i]),
      .flags     (cell_flags[i]),
      .hit       (hit[i])
    );
  end

  assign found = |hit;

endmodule

/* rtl/sorted_key_table_unit.sv */
// Top level of the sorted key table: command decode, entry count and result register.
// The table keeps up to CAPACITY entries in ascending signed key order in a row of cells
// that compare against the command key and shift left or right together. Busy stays low,
// so a transaction may be started on every clock, and its result appears with done high in
// the following cycle for exactly one cycle. Each command is a single cell compare and shift
// step. The receiver cannot stall, so results must be taken as they come. Only the count and
// done are reset; cell contents need no clearing.
`timescale 1ns / 1ps

module sorted_key_table_unit import skt_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  skt_in_t  request,
  output logic     done,
  output skt_out_t result
);

  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic             accept;
  logic             full;
  logic             found;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  status_t          status_next;
  skt_op_t          op;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CAP_CNT);

  assign op.ins  = accept && (request.command == CMD_INSERT) && !full;
  assign op.del  = accept && (request.command == CMD_DELETE);
  assign op.key  = request.key;
  assign op.name = request.name_payload;

  skt_chain #(
    .CAPACITY(CAPACITY),
    .NAME_W  (NAME_W),
    .CNT_W   (CNT_W)
  ) u_chain (
    .clk  (clk),
    .op   (op),
    .count(count),
    .found(found)
  );

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    unique case (request.command)
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (found) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.status      <= status_next;
      result.entry_count <= COUNT_W'(count_next);
    end
  end

`ifndef SYNTHESIS
  a_accept_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("Accepted transaction did not produce a result.");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("Result strobe without an accepted transaction.");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("Entry count exceeds capacity.");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (accept && request.command == CMD_INSERT && status_next == ST_FULL) |-> full)
    else $error("Insert refused while the table had room.");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    op.ins |=> (count == $past(count) + CNT_W'(1)))
    else $error("Insert did not grow the entry count by one.");
`endif

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the sorted key table: directed and random commands, scoreboard.
`timescale 1ns / 1ps

module testbench;
  import skt_pkg::*;

  localparam cmd_t CMD_NOP = cmd_t'(2'd3);
  localparam logic [NAME_MAX_W-1:0] NAME_MASK =
    (NAME_BYTES_DEF >= 8) ? {NAME_MAX_W{1'b1}} : ((64'd1 << (8 * NAME_BYTES_DEF)) - 64'd1);

  class table_scoreboard;
    logic signed [KEY_W-1:0] held_keys [CAPACITY_DEF];
    logic [NAME_MAX_W-1:0]   held_names [CAPACITY_DEF];
    int                      held;
    skt_out_t                pending [$];

    function new();
      held = 0;
    endfunction

    function void note_request(skt_in_t req);
      status_t  st;
      skt_out_t want;
      int       pos;
      int       i;
      st  = ST_DONE;
      pos = 0;
      case (req.command)
        CMD_INSERT: begin
          if (held >= CAPACITY_DEF) begin
            st = ST_FULL;
          end else begin
            while (pos < held && $signed(req.key) > $signed(held_keys[pos])) pos++;
            for (i = held; i > pos; i--) begin
              held_keys[i]  = held_keys[i-1];
              held_names[i] = held_names[i-1];
            end
            held_keys[pos]  = req.key;
            held_names[pos] = req.name_payload & NAME_MASK;
            held++;
          end
        end
        CMD_DELETE: begin
          while (pos < held && held_keys[pos] != req.key) pos++;
          if (pos >= held) begin
            st = ST_NOT_FOUND;
          end else begin
            for (i = pos; i + 1 < held; i++) begin
              held_keys[i]  = held_keys[i+1];
              held_names[i] = held_names[i+1];
            end
            held--;
          end
        end
        CMD_CLEAR: begin
          held = 0;
        end
        default: begin
        end
      endcase
      want.status      = st;
      want.entry_count = COUNT_W'(held);
      pending.push_back(want);
    endfunction

    // Returns -1 when nothing is waiting, else a mask of wrong fields: bit 0 status, bit 1 count.
    function int check_result(skt_out_t got, output skt_out_t want);
      int bad;
      bad = 0;
      want = '0;
      if (pending.size() == 0) return -1;
      want = pending.pop_front();
      if (got.status !== want.status) bad |= 1;
      if (got.entry_count !== want.entry_count) bad |= 2;
      return bad;
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  skt_in_t  request = '0;
  logic     busy;
  logic     done;
  skt_out_t result;

  table_scoreboard sb = new();
  int errors = 0;
  int gap_max = 7;

  sorted_key_table_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("[sorted_key_table_unit] ERROR");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    if (errors <= 50) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    skt_out_t want;
    int       bad;
    if (!rst && done) begin
      bad = sb.check_result(result, want);
      if (bad < 0) begin
        report($sformatf("result with nothing expected: status %0d count %0d",
                         result.status, result.entry_count));
      end else begin
        if (bad[0]) report($sformatf("status got %0d want %0d", result.status, want.status));
        if (bad[1]) begin
          report($sformatf("entry count got %0d want %0d",
                           result.entry_count, want.entry_count));
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic apply_command(cmd_t cmd, logic [KEY_W-1:0] key, logic [NAME_MAX_W-1:0] name);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request.command      <= cmd;
    request.key          <= key;
    request.name_payload <= name;
    do @(posedge clk); while (busy === 1'b1);
    sb.note_request(request);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return KEY_W'(int'($urandom_range(0, 16)) - 8);
    if (r < 8 && sb.held > 0) return sb.held_keys[$urandom_range(0, sb.held - 1)];
    return $urandom;
  endfunction

  initial begin
    logic [KEY_W-1:0] dir_keys [16];
    cmd_t             cmd;
    int               ins_pct;
    int               r;
    int               i;
    int               seg;
    dir_keys = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'd5, 32'd5,
                 32'h1, 32'd5, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFF0, 32'd100,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'd3, 32'hFFFF_FF00};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    apply_command(CMD_CLEAR, 32'd0, 64'd0);
    apply_command(CMD_DELETE, 32'd5, 64'd0);
    apply_command(CMD_NOP, 32'hFFFF_FFFF, {NAME_MAX_W{1'b1}});
    for (i = 0; i < 16; i++) begin
      case (i % 4)
        0: apply_command(CMD_INSERT, dir_keys[i], {NAME_MAX_W{1'b1}});
        1: apply_command(CMD_INSERT, dir_keys[i], 64'h0);
        2: apply_command(CMD_INSERT, dir_keys[i], 64'h5555_5555_5555_5555);
        default: apply_command(CMD_INSERT, dir_keys[i], 64'hAAAA_AAAA_AAAA_AAAA);
      endcase
    end
    apply_command(CMD_INSERT, 32'd7, 64'h1234_5678_9ABC_DEF0);
    apply_command(CMD_DELETE, 32'd77, 64'd0);
    apply_command(CMD_DELETE, 32'h8000_0000, 64'd0);
    apply_command(CMD_DELETE, 32'd5, 64'd0);
    apply_command(CMD_CLEAR, 32'd0, 64'd0);
    apply_command(CMD_NOP, 32'd0, 64'd0);

    for (seg = 0; seg < 34; seg++) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      ins_pct = $urandom_range(25, 80);
      for (i = 0; i < 50; i++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) cmd = CMD_INSERT;
        else if (r < 96) cmd = CMD_DELETE;
        else if (r < 98) cmd = CMD_CLEAR;
        else cmd = CMD_NOP;
        apply_command(cmd, pick_key(), {$urandom, $urandom});
      end
      if (seg == 0 || $urandom_range(0, 4) == 0) drain_results();
    end

    start <= 1'b0;
    for (i = 0; i < 200 && sb.pending.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    while (sb.pending.size() != 0) begin
      void'(sb.pending.pop_front());
      report("expected result never arrived");
    end
    if (errors == 0) begin
      $display("[sorted_key_table_unit] OK");
    end else begin
      $display("[sorted_key_table_unit] ERROR");
    end
    $finish;
  end

endmodule
